// File: design/hsvb_pkg.sv
package hsvb_pkg;

    // widest channel the block is built for; narrower builds use the low bits
    localparam int MAX_CH_BITS = 24;
    localparam int AMOUNT_BITS = 17;
    localparam int FACTOR_BITS = 18;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [AMOUNT_BITS-1:0] AMOUNT_ONE = 17'h10000;
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = 18'h10000;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    // classified color, front to back
    typedef struct packed {
        logic                    lighter;
        logic [FACTOR_BITS-1:0]  factor;
        logic [15:0]             alpha;
        logic [MAX_CH_BITS-1:0]  mx;
        logic [MAX_CH_BITS-1:0]  d;
        logic [MAX_CH_BITS-1:0]  n;
        sector_t                 sector;
    } class_t;

    function automatic sector_t next_sector(input sector_t s);
        sector_t r;
        case (s)
            SEC_RED_YELLOW:   r = SEC_YELLOW_GREEN;
            SEC_YELLOW_GREEN: r = SEC_GREEN_CYAN;
            SEC_GREEN_CYAN:   r = SEC_CYAN_BLUE;
            SEC_CYAN_BLUE:    r = SEC_BLUE_MAGENTA;
            SEC_BLUE_MAGENTA: r = SEC_MAGENTA_RED;
            default:          r = SEC_RED_YELLOW;
        endcase
        return r;
    endfunction

endpackage

// File: design/hsv_color_brightness_adjust.sv
// HSV brightness adjust: darkens or lightens one RGBA color word per cycle unless stalled.
// Input channel: in_valid / in_stall with action, red_in, green_in, blue_in,
// alpha_in and amount (Q1.16, saturates at 1.0). Output channel: out_valid /
// out_stall with red_out, green_out, blue_out and alpha_out.
// A word moves when valid is high and stall is low at a rising clock edge.
// Throughput: one word per cycle while out_stall does not freeze the back
// pipeline. The hue and saturation dividers build the quotient bit by bit
// in their own pipeline; the rest of the path is classify, scaling, two
// rounds of multiply and full-scale correction, and the output register.
// The front stage classifies the color (max, min, hue sector) and hands the
// word to a four-entry queue; the back pipeline pulls from the queue.
// When out_stall holds a pending result, the whole back pipeline freezes,
// and the queue plus the front register keep taking words until full;
// in_stall then rises. Reset (rst_n low, asynchronous) empties the queue and
// clears every valid bit; no word is held across reset.
module hsv_color_brightness_adjust
    import hsvb_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    input  logic [15:0] alpha_in,
    input  logic [16:0] amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out,
    output logic [15:0] alpha_out
);
    // front to queue
    logic   push, q_full;
    class_t push_word;
    // queue to back
    logic   pop, q_empty;
    class_t pop_word;

    // classify and register one word
    hsvb_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .amount     (amount),
        .push       (push),
        .push_word  (push_word),
        .queue_full (q_full)
    );

    // decouple the two sides
    hsvb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_word  (pop_word)
    );

    // divide, scale, convert back and drive the result word
    hsvb_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_word    (pop_word),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

endmodule

// File: design/hsvb_front.sv
module hsvb_front
    import hsvb_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    input  logic [15:0] alpha_in,
    input  logic [AMOUNT_BITS-1:0] amount,
    output logic        push,
    output class_t      push_word,
    input  logic        queue_full
);
    localparam int W = CHANNEL_BITS;

    logic   front_valid_reg, front_valid_next;
    class_t front_word_reg, front_word_next;
    logic   accept;

    logic [W-1:0] r, g, b, mx, mn, d, n;
    logic [AMOUNT_BITS-1:0] amt;
    sector_t sec;

    assign in_stall  = front_valid_reg && queue_full;
    assign accept    = in_valid && !in_stall;
    assign push      = front_valid_reg && !queue_full;
    assign push_word = front_word_reg;

    always_comb
    begin
        r = W'(red_in);
        g = W'(green_in);
        b = W'(blue_in);
        amt = (amount > AMOUNT_ONE) ? AMOUNT_ONE : amount;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        d  = mx - mn;
        sec = SEC_RED_YELLOW;
        n   = '0;
        if (d != '0)
        begin
            if (mx == r)
            begin
                if (g >= b)
                begin
                    sec = SEC_RED_YELLOW;
                    n   = g - b;
                end
                else
                begin
                    sec = SEC_MAGENTA_RED;
                    n   = d - (b - g);
                end
            end
            else if (mx == g)
            begin
                if (b >= r)
                begin
                    sec = SEC_GREEN_CYAN;
                    n   = b - r;
                end
                else
                begin
                    sec = SEC_YELLOW_GREEN;
                    n   = d - (r - b);
                end
            end
            else
            begin
                if (r >= g)
                begin
                    sec = SEC_BLUE_MAGENTA;
                    n   = r - g;
                end
                else
                begin
                    sec = SEC_CYAN_BLUE;
                    n   = d - (g - r);
                end
            end
        end
        front_word_next.lighter = action;
        front_word_next.factor  = action ? (FACTOR_ONE + FACTOR_BITS'(amt))
                                         : (FACTOR_ONE - FACTOR_BITS'(amt));
        front_word_next.alpha   = alpha_in;
        front_word_next.mx      = MAX_CH_BITS'(mx);
        front_word_next.d       = MAX_CH_BITS'(d);
        front_word_next.n       = MAX_CH_BITS'(n);
        front_word_next.sector  = sec;
    end

    always_comb
    begin
        if (accept)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            front_word_reg <= front_word_next;
    end

endmodule

// File: design/hsvb_queue.sv
module hsvb_queue
    import hsvb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  class_t push_word,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output class_t pop_word
);
    class_t slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_word = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_word;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

// File: design/hsvb_div.sv
module hsvb_div #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         en,
    input  logic [2*W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo
);
    // restoring division, one quotient bit per stage; needs num < den * 2^W
    logic [W-1:0] rem_reg [W];
    logic [W-1:0] low_reg [W];
    logic [W-1:0] q_reg   [W];
    logic [W-1:0] den_reg [W];

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        logic [W-1:0] rem_in, low_in, q_in, den_in;
        logic [W:0]   trial;
        logic         ge;
        if (i == 0)
        begin : g_first
            assign rem_in = num[2*W-1:W];
            assign low_in = num[W-1:0];
            assign q_in   = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign den_in = den_reg[i-1];
        end
        assign trial = {rem_in, low_in[W-1]};
        assign ge    = (trial >= {1'b0, den_in});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? W'(trial - {1'b0, den_in}) : W'(trial);
                low_reg[i] <= {low_in[W-2:0], 1'b0};
                q_reg[i]   <= {q_in[W-2:0], ge};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = q_reg[W-1];

endmodule

// File: design/hsvb_back.sv
module hsvb_back
    import hsvb_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  class_t      q_word,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out,
    output logic [15:0] alpha_out
);
    localparam int W  = CHANNEL_BITS;
    localparam int PW = W + FACTOR_BITS;
    localparam int TW = PW - 16;
    localparam logic [W-1:0]   FS    = {W{1'b1}};
    localparam logic [W:0]     FS_X  = {1'b0, FS};
    localparam logic [W:0]     FS_2X = {FS, 1'b0};
    localparam logic [2*W-1:0] HALF  = (2*W)'(FS >> 1);

    typedef struct packed {
        logic          lighter;
        logic [PW-1:0] prod;
        logic [15:0]   alpha;
        logic          d_zero;
        logic          mx_zero;
        sector_t       sector;
    } side_t;

    function automatic logic [W-1:0] div_fs(input logic [2*W-1:0] p);
        logic [W-1:0] q1;
        logic [W:0]   rem;
        logic [W:0]   q;
        q1  = p[2*W-1:W];
        rem = {1'b0, p[W-1:0]} + {1'b0, q1};
        q   = {1'b0, q1} + (W+1)'(rem >= FS_X) + (W+1)'(rem >= FS_2X);
        return q[W-1:0];
    endfunction

    logic en;

    // stage A
    logic            a_valid_reg;
    side_t           a_side_reg;
    logic [2*W-1:0]  a_numf_reg, a_nums_reg;
    logic [W-1:0]    a_denf_reg, a_dens_reg;

    // divider line
    logic            dv_valid_reg [W];
    side_t           dv_side_reg  [W];
    logic [W-1:0]    quo_f, quo_s;

    // stage B
    logic            b_valid_reg;
    logic [W-1:0]    b_v_reg, b_s_reg, b_f_reg;
    sector_t         b_sec_reg;
    logic [15:0]     b_alpha_reg;

    // stage C
    logic            c_valid_reg;
    logic [2*W-1:0]  c_pfs_reg, c_pgs_reg, c_px_reg;
    logic [W-1:0]    c_v_reg;
    sector_t         c_sec_reg;
    logic [15:0]     c_alpha_reg;

    // stage D
    logic            d_valid_reg;
    logic [W-1:0]    d_mf_reg, d_mg_reg, d_x_reg, d_v_reg;
    sector_t         d_sec_reg;
    logic [15:0]     d_alpha_reg;

    // stage E
    logic            e_valid_reg;
    logic [2*W-1:0]  e_py_reg, e_pz_reg;
    logic [W-1:0]    e_x_reg, e_v_reg;
    sector_t         e_sec_reg;
    logic [15:0]     e_alpha_reg;

    // output
    logic            o_valid_reg;
    logic [15:0]     o_r_reg, o_g_reg, o_b_reg, o_a_reg;

    assign en  = !(o_valid_reg && out_stall);
    assign pop = en && !q_empty;

    // stage A: form numerators, scale value
    logic [W-1:0] qa_mx, qa_d, qa_n;
    side_t        side_a;
    always_comb
    begin
        qa_mx = q_word.mx[W-1:0];
        qa_d  = q_word.d[W-1:0];
        qa_n  = q_word.n[W-1:0];
        side_a.lighter = q_word.lighter;
        side_a.prod    = PW'(qa_mx) * PW'(q_word.factor);
        side_a.alpha   = q_word.alpha;
        side_a.d_zero  = (qa_d == '0);
        side_a.mx_zero = (qa_mx == '0);
        side_a.sector  = q_word.sector;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= side_a;
            a_numf_reg <= {qa_n, {W{1'b0}}} - (2*W)'(qa_n) + (2*W)'(qa_d >> 1);
            a_nums_reg <= {qa_d, {W{1'b0}}} - (2*W)'(qa_d) + (2*W)'(qa_mx >> 1);
            a_denf_reg <= qa_d;
            a_dens_reg <= qa_mx;
        end
    end

    hsvb_div #(.W(W)) u_div_f (
        .clk (clk),
        .en  (en),
        .num (a_numf_reg),
        .den (a_denf_reg),
        .quo (quo_f)
    );

    hsvb_div #(.W(W)) u_div_s (
        .clk (clk),
        .en  (en),
        .num (a_nums_reg),
        .den (a_dens_reg),
        .quo (quo_s)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= a_side_reg;
            for (int i = 1; i < W; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // stage B: fix hue wrap, adjust value and saturation
    side_t         sb;
    logic [W-1:0]  b_f_next, b_s_next, b_v_next;
    sector_t       b_sec_next;
    logic [PW-1:0] rounded;
    logic [TW-1:0] t, excess;
    always_comb
    begin
        sb         = dv_side_reg[W-1];
        b_f_next   = quo_f;
        b_sec_next = sb.sector;
        if (sb.d_zero)
            b_f_next = '0;
        else if (quo_f >= FS)
        begin
            b_f_next   = '0;
            b_sec_next = next_sector(sb.sector);
        end
        b_s_next = sb.mx_zero ? '0 : quo_s;
        rounded  = sb.prod + PW'(32768);
        t        = rounded[PW-1:16];
        excess   = t - TW'(FS);
        b_v_next = t[W-1:0];
        if (sb.lighter && (t > TW'(FS)))
        begin
            b_s_next = (excess >= TW'(b_s_next)) ? '0 : b_s_next - excess[W-1:0];
            b_v_next = FS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_v_reg     <= b_v_next;
            b_s_reg     <= b_s_next;
            b_f_reg     <= b_f_next;
            b_sec_reg   <= b_sec_next;
            b_alpha_reg <= sb.alpha;
        end
    end

    // stage C: first products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_pfs_reg   <= (2*W)'(b_f_reg) * (2*W)'(b_s_reg) + HALF;
            c_pgs_reg   <= (2*W)'(FS - b_f_reg) * (2*W)'(b_s_reg) + HALF;
            c_px_reg    <= (2*W)'(b_v_reg) * (2*W)'(FS - b_s_reg) + HALF;
            c_v_reg     <= b_v_reg;
            c_sec_reg   <= b_sec_reg;
            c_alpha_reg <= b_alpha_reg;
        end
    end

    // stage D: scale back to full scale
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_mf_reg    <= div_fs(c_pfs_reg);
            d_mg_reg    <= div_fs(c_pgs_reg);
            d_x_reg     <= div_fs(c_px_reg);
            d_v_reg     <= c_v_reg;
            d_sec_reg   <= c_sec_reg;
            d_alpha_reg <= c_alpha_reg;
        end
    end

    // stage E: second products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_py_reg    <= (2*W)'(d_v_reg) * (2*W)'(FS - d_mf_reg) + HALF;
            e_pz_reg    <= (2*W)'(d_v_reg) * (2*W)'(FS - d_mg_reg) + HALF;
            e_x_reg     <= d_x_reg;
            e_v_reg     <= d_v_reg;
            e_sec_reg   <= d_sec_reg;
            e_alpha_reg <= d_alpha_reg;
        end
    end

    // output: pick channels by sector
    logic [W-1:0] y, z, ro, go, bo;
    always_comb
    begin
        y = div_fs(e_py_reg);
        z = div_fs(e_pz_reg);
        case (e_sec_reg)
            SEC_RED_YELLOW:   begin ro = e_v_reg; go = z;       bo = e_x_reg; end
            SEC_YELLOW_GREEN: begin ro = y;       go = e_v_reg; bo = e_x_reg; end
            SEC_GREEN_CYAN:   begin ro = e_x_reg; go = e_v_reg; bo = z;       end
            SEC_CYAN_BLUE:    begin ro = e_x_reg; go = y;       bo = e_v_reg; end
            SEC_BLUE_MAGENTA: begin ro = z;       go = e_x_reg; bo = e_v_reg; end
            default:          begin ro = e_v_reg; go = e_x_reg; bo = y;       end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_r_reg <= 16'(ro);
            o_g_reg <= 16'(go);
            o_b_reg <= 16'(bo);
            o_a_reg <= e_alpha_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int i = 0; i < W; i++)
                dv_valid_reg[i] <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg     <= !q_empty;
            dv_valid_reg[0] <= a_valid_reg;
            for (int i = 1; i < W; i++)
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            b_valid_reg <= dv_valid_reg[W-1];
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            o_valid_reg <= e_valid_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign red_out   = o_r_reg;
    assign green_out = o_g_reg;
    assign blue_out  = o_b_reg;
    assign alpha_out = o_a_reg;

endmodule
